>>> rtl/core/lhd_pkg.sv
// lhd_pkg: shared types, constants and helpers for the luma histogram block
// depends on nothing; imported by every module under rtl/core except lhd_ram
package lhd_pkg;

   localparam int CNT_W      = 25;
   localparam int LUMA_W     = 8;
   localparam int DIM_W      = 13;
   localparam int STEP_W     = 5;
   localparam int STEP_MAX   = 16;
   localparam int MOD_W      = 4;
   localparam int FRAC_W     = 17;
   localparam int FRAC_FRAC  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_STEP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STEP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_LEVEL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_FRACTION = 3'd5;

   localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH   = 13'd1920;
   localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT  = 13'd1080;
   localparam logic [STEP_W-1:0] RST_COL_STEP      = 5'd1;
   localparam logic [STEP_W-1:0] RST_ROW_STEP      = 5'd1;
   localparam logic [LUMA_W-1:0] RST_DARK_LEVEL    = 8'd32;
   localparam logic [FRAC_W-1:0] RST_DARK_FRACTION = 17'd58982;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_CALC,
      ST_CMP,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic keep;
      logic end_row;
      logic end_frame;
   } pos_flags_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (&v) ? v : v + CNT_W'(1);
   endfunction

   // step register to a mod-counter select, zero acts as one, above 16 as 16
   function automatic logic [MOD_W-1:0] step_sel(input logic [STEP_W-1:0] s);
      logic [MOD_W-1:0] r;
      if (s == '0) begin
         r = '0;
      end else if (s > STEP_W'(STEP_MAX)) begin
         r = MOD_W'(STEP_MAX - 1);
      end else begin
         r = MOD_W'(s - STEP_W'(1));
      end
      step_sel = r;
   endfunction

endpackage

>>> rtl/core/lhd_ram.sv
// lhd_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
module lhd_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lhd_pos.sv
// lhd_pos: column and row tracking with per-step phase counters
// depends on lhd_pkg
module lhd_pos import lhd_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [DIM_W-1:0]    frame_width,
   input  logic [DIM_W-1:0]    frame_height,
   input  logic [STEP_W-1:0]   col_step,
   input  logic [STEP_W-1:0]   row_step,
   output pos_flags_type       flags
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam logic [DIM_W:0] MAX_DIM_C = (DIM_W+1)'(MAX_DIM);

   logic [POS_W-1:0] col_pos_ff, col_pos_in;
   logic [POS_W-1:0] row_pos_ff, row_pos_in;
   logic [MOD_W-1:0] col_mod_ff [STEP_MAX];
   logic [MOD_W-1:0] col_mod_in [STEP_MAX];
   logic [MOD_W-1:0] row_mod_ff [STEP_MAX];
   logic [MOD_W-1:0] row_mod_in [STEP_MAX];
   logic [POS_W-1:0] last_col;
   logic [POS_W-1:0] last_row;
   logic             end_row;
   logic             end_frame;

   function automatic logic [POS_W-1:0] last_pos(input logic [DIM_W-1:0] d);
      logic [POS_W-1:0] r;
      if (d == '0) begin
         r = '0;
      end else if ({1'b0, d} > MAX_DIM_C) begin
         r = POS_W'(MAX_DIM - 1);
      end else begin
         r = POS_W'(d - DIM_W'(1));
      end
      last_pos = r;
   endfunction

   always_comb begin
      last_col  = last_pos(frame_width);
      last_row  = last_pos(frame_height);
      end_row   = col_pos_ff >= last_col;
      end_frame = end_row && (row_pos_ff >= last_row);
      flags.keep      = (col_mod_ff[step_sel(col_step)] == '0) &&
                        (row_mod_ff[step_sel(row_step)] == '0);
      flags.end_row   = end_row;
      flags.end_frame = end_frame;
   end

   always_comb begin
      col_pos_in = end_row ? '0 : col_pos_ff + POS_W'(1);
      if (!end_row) begin
         row_pos_in = row_pos_ff;
      end else if (end_frame) begin
         row_pos_in = '0;
      end else begin
         row_pos_in = row_pos_ff + POS_W'(1);
      end
      for (int k = 0; k < STEP_MAX; k++) begin
         if (end_row || col_mod_ff[k] == MOD_W'(k)) begin
            col_mod_in[k] = '0;
         end else begin
            col_mod_in[k] = col_mod_ff[k] + MOD_W'(1);
         end
         if (!end_row) begin
            row_mod_in[k] = row_mod_ff[k];
         end else if (end_frame || row_mod_ff[k] == MOD_W'(k)) begin
            row_mod_in[k] = '0;
         end else begin
            row_mod_in[k] = row_mod_ff[k] + MOD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         for (int k = 0; k < STEP_MAX; k++) begin
            col_mod_ff[k] <= '0;
            row_mod_ff[k] <= '0;
         end
      end else if (advance) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         for (int k = 0; k < STEP_MAX; k++) begin
            col_mod_ff[k] <= col_mod_in[k];
            row_mod_ff[k] <= row_mod_in[k];
         end
      end
   end

endmodule

>>> rtl/core/lhd_dark.sv
// lhd_dark: dark ratio test, one registered multiply then one compare
// depends on lhd_pkg
module lhd_dark import lhd_pkg::*; (
   input  logic              clock,
   input  logic              calc_go,
   input  logic              cmp_go,
   input  logic [FRAC_W-1:0] dark_fraction,
   input  logic [CNT_W-1:0]  dark_total,
   input  logic [CNT_W-1:0]  sample_total,
   output logic              is_dark
);

   localparam int PROD_W = FRAC_FRAC + CNT_W;

   logic [PROD_W-1:0] prod_ff;
   logic              full_ff;
   logic              dark_ff, dark_in;
   logic [PROD_W-1:0] scaled_dark;

   always_comb begin
      scaled_dark = {dark_total, {FRAC_FRAC{1'b0}}};
      if (sample_total == '0) begin
         dark_in = 1'b0;
      end else if (full_ff) begin
         dark_in = dark_total >= sample_total;
      end else begin
         dark_in = scaled_dark >= prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (calc_go) begin
         // fraction at or above one compares totals directly
         full_ff <= dark_fraction[FRAC_FRAC];
         prod_ff <= PROD_W'(dark_fraction[FRAC_FRAC-1:0]) * PROD_W'(sample_total);
      end
      if (cmp_go) begin
         dark_ff <= dark_in;
      end
   end

   assign is_dark = dark_ff;

endmodule

>>> rtl/core/luma_histogram_dark_frame.sv
// luma_histogram_dark_frame: 64-bin luma histogram with dark frame flag
// one pixel per cycle while not busy, into a read-modify-write bin RAM; bins stream out at frame end
// depends on lhd_pkg, lhd_ram, lhd_pos, lhd_dark
// after the last pixel is taken, ST_CALC and ST_CMP run, then ST_FLUSH reads out one bin per cycle
// throughput: 1 pixel per cycle while not busy, same-bin updates forwarded around the RAM read
// busy after the last pixel through ST_CALC, ST_CMP, ST_FLUSH, ST_DRAIN (dark compare, then RAM readout)
// synchronous active-high reset restores registers, positions and empty bins;
// the receiver cannot stall, each bin is on the rsp_ ports for one cycle
module luma_histogram_dark_frame import lhd_pkg::*; #(
   parameter int NUM_BINS = 64,
   parameter int MAX_DIM  = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [LUMA_W-1:0]           req_luma,
   output logic                        rsp_valid,
   output logic [$clog2(NUM_BINS)-1:0] rsp_bin_index,
   output logic [CNT_W-1:0]            rsp_bin_count,
   output logic                        rsp_is_dark,
   output logic                        rsp_last_bin,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int BIN_W  = $clog2(NUM_BINS);
   localparam int BPROD_W = 2 * LUMA_W + 1;
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

   logic [DIM_W-1:0]  frame_width_ff;
   logic [DIM_W-1:0]  frame_height_ff;
   logic [STEP_W-1:0] col_step_ff;
   logic [STEP_W-1:0] row_step_ff;
   logic [LUMA_W-1:0] dark_level_ff;
   logic [FRAC_W-1:0] dark_fraction_ff;

   state_type state_ff, state_in;
   logic      flush_rd;
   logic      calc_go;
   logic      cmp_go;

   pos_flags_type     flags;
   logic              accept;
   logic              take;
   logic [BPROD_W-1:0] bin_prod;
   logic [BIN_W-1:0]  pix_bin;

   logic [CNT_W-1:0]  sample_total_ff;
   logic [CNT_W-1:0]  dark_total_ff;
   logic              is_dark;

   logic              p1_valid_ff;
   logic [BIN_W-1:0]  p1_bin_ff;
   logic              fl_valid_ff;
   logic [BIN_W-1:0]  fl_idx_ff;
   logic [BIN_W-1:0]  flush_idx_ff;

   logic              rd_en;
   logic [BIN_W-1:0]  rd_addr;
   logic [BIN_W-1:0]  rd_addr_ff;
   logic              rd_ok_ff;
   logic [CNT_W-1:0]  ram_rdata;
   logic [CNT_W-1:0]  cur_count;
   logic              wr_en;
   logic [BIN_W-1:0]  wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic              lw_valid_ff;
   logic [BIN_W-1:0]  lw_addr_ff;
   logic [CNT_W-1:0]  lw_data_ff;
   logic              entry_ok_ff [NUM_BINS];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= RST_FRAME_WIDTH;
         frame_height_ff  <= RST_FRAME_HEIGHT;
         col_step_ff      <= RST_COL_STEP;
         row_step_ff      <= RST_ROW_STEP;
         dark_level_ff    <= RST_DARK_LEVEL;
         dark_fraction_ff <= RST_DARK_FRACTION;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_wdata[DIM_W-1:0];
            CSR_COL_STEP:      col_step_ff      <= csr_wdata[STEP_W-1:0];
            CSR_ROW_STEP:      row_step_ff      <= csr_wdata[STEP_W-1:0];
            CSR_DARK_LEVEL:    dark_level_ff    <= csr_wdata[LUMA_W-1:0];
            CSR_DARK_FRACTION: dark_fraction_ff <= csr_wdata[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN:   if (accept && flags.end_frame) state_in = ST_CALC;
         ST_CALC:  state_in = ST_CMP;
         ST_CMP:   state_in = ST_FLUSH;
         ST_FLUSH: if (flush_idx_ff == LAST_BIN) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_RUN;
         default:  state_in = ST_RUN;
      endcase
   end

   always_comb begin
      busy     = 1'b1;
      flush_rd = 1'b0;
      calc_go  = 1'b0;
      cmp_go   = 1'b0;
      case (state_ff)
         ST_RUN:   busy = 1'b0;
         ST_CALC:  calc_go = 1'b1;
         ST_CMP:   cmp_go = 1'b1;
         ST_FLUSH: flush_rd = 1'b1;
         ST_DRAIN: ;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   lhd_pos #(
      .MAX_DIM (MAX_DIM)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .col_step     (col_step_ff),
      .row_step     (row_step_ff),
      .flags        (flags)
   );

   assign accept   = start && !busy;
   assign take     = accept && flags.keep;
   assign bin_prod = BPROD_W'(req_luma) * BPROD_W'(NUM_BINS);
   assign pix_bin  = bin_prod[LUMA_W +: BIN_W];

   // running totals
   always_ff @(posedge clock) begin
      if (reset || cmp_go) begin
         sample_total_ff <= '0;
         dark_total_ff   <= '0;
      end else if (take) begin
         sample_total_ff <= sat_inc(sample_total_ff);
         if (req_luma <= dark_level_ff) begin
            dark_total_ff <= sat_inc(dark_total_ff);
         end
      end
   end

   lhd_dark u_dark (
      .clock         (clock),
      .calc_go       (calc_go),
      .cmp_go        (cmp_go),
      .dark_fraction (dark_fraction_ff),
      .dark_total    (dark_total_ff),
      .sample_total  (sample_total_ff),
      .is_dark       (is_dark)
   );

   // bin RAM read side
   assign rd_en   = take || flush_rd;
   assign rd_addr = flush_rd ? flush_idx_ff : pix_bin;

   always_comb begin
      if (lw_valid_ff && lw_addr_ff == rd_addr_ff) begin
         cur_count = lw_data_ff;
      end else if (rd_ok_ff) begin
         cur_count = ram_rdata;
      end else begin
         cur_count = '0;
      end
   end

   // write side: bin update from a pixel, or clear behind the readout
   always_comb begin
      wr_en   = p1_valid_ff || fl_valid_ff;
      wr_addr = p1_valid_ff ? p1_bin_ff : fl_idx_ff;
      wr_data = p1_valid_ff ? sat_inc(cur_count) : '0;
   end

   lhd_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_BINS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         fl_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         rd_ok_ff     <= 1'b0;
         flush_idx_ff <= '0;
         for (int i = 0; i < NUM_BINS; i++) begin
            entry_ok_ff[i] <= 1'b0;
         end
      end else begin
         p1_valid_ff <= take;
         fl_valid_ff <= flush_rd;
         lw_valid_ff <= wr_en;
         if (rd_en) begin
            rd_ok_ff <= entry_ok_ff[rd_addr];
         end
         if (wr_en) begin
            entry_ok_ff[wr_addr] <= 1'b1;
         end
         if (cmp_go) begin
            flush_idx_ff <= '0;
         end else if (flush_rd) begin
            flush_idx_ff <= flush_idx_ff + BIN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_bin_ff <= pix_bin;
      fl_idx_ff <= flush_idx_ff;
      if (rd_en) begin
         rd_addr_ff <= rd_addr;
      end
      lw_addr_ff <= wr_addr;
      lw_data_ff <= wr_data;
   end

   assign rsp_valid     = fl_valid_ff;
   assign rsp_bin_index = fl_idx_ff;
   assign rsp_bin_count = cur_count;
   assign rsp_is_dark   = is_dark;
   assign rsp_last_bin  = fl_valid_ff && (fl_idx_ff == LAST_BIN);

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("bin beat outside readout");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(p1_valid_ff && fl_valid_ff))
      else $error("pixel update and readout clear collide on the write port");

   a_bins_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_bin |=> rsp_valid)
      else $error("gap in bin readout");

   a_bins_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_bin |=> rsp_bin_index == $past(rsp_bin_index) + BIN_W'(1))
      else $error("bin index out of order");

   a_no_pixel_in_readout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !p1_valid_ff)
      else $error("pixel update during readout");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for luma_histogram_dark_frame, directed table, an oversized run, then random frames
// bins are predicted from a behavioral histogram kept here; depends on lhd_pkg and the rtl/core sources
module testbench;
   import lhd_pkg::*;

   localparam int NUM_BINS       = 64;
   localparam int MAX_DIM        = 4096;
   localparam int RAND_PIXELS    = 200;
   localparam int BIG_PIXELS     = 16;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int DIR_ROWS       = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG_B = 3'd7;

   typedef enum logic {ROW_CSR, ROW_PIXEL} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  wdata;
      logic [LUMA_W-1:0]      luma;
      logic                   typed;
      logic [5:0]             bin;
      logic [CNT_W-1:0]       cnt;
      logic                   dark;
   } stim_row_type;

   typedef struct packed {
      logic [5:0]       index;
      logic [CNT_W-1:0] count;
      logic             dark;
      logic             last;
   } bin_beat_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [LUMA_W-1:0]     req_luma;
   logic                  rsp_valid;
   logic [5:0]            rsp_bin_index;
   logic [CNT_W-1:0]      rsp_bin_count;
   logic                  rsp_is_dark;
   logic                  rsp_last_bin;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // histogram model state and its copy of the registers
   logic [DIM_W-1:0]      cfg_width;
   logic [DIM_W-1:0]      cfg_height;
   logic [STEP_W-1:0]     cfg_col_step;
   logic [STEP_W-1:0]     cfg_row_step;
   logic [LUMA_W-1:0]     cfg_level;
   logic [FRAC_W-1:0]     cfg_fraction;
   logic [11:0]           col_at;
   logic [11:0]           row_at;
   logic [CNT_W-1:0]      bin_hist [NUM_BINS];
   logic [CNT_W-1:0]      dark_kept;
   logic [CNT_W-1:0]      kept_pixels;

   bin_beat_type          pending_bins [$];
   bin_beat_type          want_bin;
   stim_row_type          dir_tab [DIR_ROWS];
   int unsigned           mismatches  = 0;
   int unsigned           idle_cycles = 0;
   int unsigned           pixels_sent = 0;

   luma_histogram_dark_frame #(
      .NUM_BINS (NUM_BINS),
      .MAX_DIM  (MAX_DIM)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_luma      (req_luma),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_count (rsp_bin_count),
      .rsp_is_dark   (rsp_is_dark),
      .rsp_last_bin  (rsp_last_bin),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return v;
   endfunction

   function automatic logic [STEP_W-1:0] step_eff(input logic [STEP_W-1:0] v);
      if (v == '0) begin
         return STEP_W'(1);
      end else if (v > STEP_W'(STEP_MAX)) begin
         return STEP_W'(STEP_MAX);
      end
      return v;
   endfunction

   function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + CNT_W'(1);
   endfunction

   task automatic hist_reset();
      cfg_width    = RST_FRAME_WIDTH;
      cfg_height   = RST_FRAME_HEIGHT;
      cfg_col_step = RST_COL_STEP;
      cfg_row_step = RST_ROW_STEP;
      cfg_level    = RST_DARK_LEVEL;
      cfg_fraction = RST_DARK_FRACTION;
      col_at       = '0;
      row_at       = '0;
      dark_kept    = '0;
      kept_pixels  = '0;
      foreach (bin_hist[i]) bin_hist[i] = '0;
   endtask

   // one pixel into the histogram; on the frame's last pixel queue all bins
   task automatic hist_take(input logic [LUMA_W-1:0] luma, output bit frame_end);
      logic [DIM_W-1:0]  w;
      logic [DIM_W-1:0]  h;
      logic [STEP_W-1:0] cs;
      logic [STEP_W-1:0] rs;
      logic [5:0]        b;
      bit                end_row;
      bit                dark;
      longint unsigned   frac;
      longint unsigned   dark_lhs;
      longint unsigned   dark_rhs;
      bin_beat_type      beat;
      w         = dim_eff(cfg_width);
      h         = dim_eff(cfg_height);
      cs        = step_eff(cfg_col_step);
      rs        = step_eff(cfg_row_step);
      end_row   = {1'b0, col_at} >= w - DIM_W'(1);
      frame_end = end_row && ({1'b0, row_at} >= h - DIM_W'(1));
      if ((col_at % cs) == 0 && (row_at % rs) == 0) begin
         b           = luma[7:2];
         bin_hist[b] = cnt_up(bin_hist[b]);
         kept_pixels = cnt_up(kept_pixels);
         if (luma <= cfg_level) begin
            dark_kept = cnt_up(dark_kept);
         end
      end
      if (!end_row) begin
         col_at = col_at + 12'd1;
      end else begin
         col_at = '0;
         row_at = frame_end ? 12'd0 : row_at + 12'd1;
      end
      if (frame_end) begin
         frac     = (cfg_fraction > FRAC_W'(65536)) ? 65536 : cfg_fraction;
         dark_lhs = dark_kept;
         dark_lhs = dark_lhs << FRAC_FRAC;
         dark_rhs = kept_pixels;
         dark_rhs = dark_rhs * frac;
         dark     = (kept_pixels != '0) && (dark_lhs >= dark_rhs);
         for (int i = 0; i < NUM_BINS; i++) begin
            beat.index  = 6'(i);
            beat.count  = bin_hist[i];
            beat.dark   = dark;
            beat.last   = (i == NUM_BINS - 1);
            pending_bins.push_back(beat);
            bin_hist[i] = '0;
         end
         dark_kept   = '0;
         kept_pixels = '0;
      end
   endtask

   task automatic cfg_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:   cfg_width    = data[DIM_W-1:0];
         CSR_FRAME_HEIGHT:  cfg_height   = data[DIM_W-1:0];
         CSR_COL_STEP:      cfg_col_step = data[STEP_W-1:0];
         CSR_ROW_STEP:      cfg_row_step = data[STEP_W-1:0];
         CSR_DARK_LEVEL:    cfg_level    = data[LUMA_W-1:0];
         CSR_DARK_FRACTION: cfg_fraction = data[FRAC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_pixel(input logic [LUMA_W-1:0] luma, output bit frame_end);
      start    <= 1'b1;
      req_luma <= luma;
      @(posedge clock);
      while (busy) @(posedge clock);
      pixels_sent++;
      hist_take(luma, frame_end);
   endtask

   // block is idle once every bin is out and the pixel pipeline has emptied
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned n_pix, input bit stop_at_frame, input bit calm,
                            input bit dark_bias);
      int unsigned       burst_left;
      bit                fe;
      logic [LUMA_W-1:0] luma;
      burst_left = $urandom_range(1, 24);
      for (int unsigned k = 0; k < n_pix; k++) begin
         luma = dark_bias ? LUMA_W'($urandom_range(0, cfg_level))
                          : LUMA_W'($urandom_range(0, 255));
         send_pixel(luma, fe);
         if (stop_at_frame && fe) break;
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!calm) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
      end
   endtask

   task automatic rand_settings();
      cfg_write(CSR_FRAME_WIDTH, CSR_DATA_W'($urandom_range(0, 6)));
      cfg_write(CSR_FRAME_HEIGHT, CSR_DATA_W'($urandom_range(0, 4)));
      if ($urandom_range(0, 1)) begin
         cfg_write(CSR_COL_STEP, CSR_DATA_W'(($urandom_range(0, 3) == 0) ?
                   $urandom_range(0, 31) : $urandom_range(1, 3)));
      end
      if ($urandom_range(0, 1)) begin
         cfg_write(CSR_ROW_STEP, CSR_DATA_W'(($urandom_range(0, 3) == 0) ?
                   $urandom_range(0, 31) : $urandom_range(1, 3)));
      end
      if ($urandom_range(0, 1)) begin
         cfg_write(CSR_DARK_LEVEL, CSR_DATA_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1)) begin
         cfg_write(CSR_DARK_FRACTION, CSR_DATA_W'(($urandom_range(0, 7) == 0) ?
                   $urandom_range(65536, 131071) : $urandom_range(0, 65536)));
      end
      if ($urandom_range(0, 7) == 0) begin
         cfg_write($urandom_range(0, 1) ? CSR_NO_REG_A : CSR_NO_REG_B, CSR_DATA_W'($urandom));
      end
      csr_we <= 1'b0;
   endtask

   // bin beats against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected bin beat: idx %0d cnt %0d dark %0b last %0b",
                        rsp_bin_index, rsp_bin_count, rsp_is_dark, rsp_last_bin);
            end
         end else begin
            want_bin = pending_bins.pop_front();
            if (rsp_bin_index !== want_bin.index || rsp_bin_count !== want_bin.count ||
                rsp_is_dark !== want_bin.dark || rsp_last_bin !== want_bin.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("bin mismatch: exp idx %0d cnt %0d dark %0b last %0b",
                           want_bin.index, want_bin.count, want_bin.dark, want_bin.last);
                  $display("              got idx %0d cnt %0d dark %0b last %0b",
                           rsp_bin_index, rsp_bin_count, rsp_is_dark, rsp_last_bin);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      bin_beat_type beat;
      bit           fe;
      bit           prev_pix;
      int unsigned  base;
      int unsigned  span;
      // kind, index, wdata, luma, typed, bin, count, dark
      dir_tab = '{
         '{ROW_CSR,   CSR_FRAME_WIDTH,   17'd1,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_FRAME_HEIGHT,  17'd1,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd0,   1'b1, 6'd0,  25'd1, 1'b1},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd255, 1'b1, 6'd63, 25'd1, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd32,  1'b1, 6'd8,  25'd1, 1'b1},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd33,  1'b1, 6'd8,  25'd1, 1'b0},
         '{ROW_CSR,   CSR_DARK_FRACTION, 17'd0,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd200, 1'b1, 6'd50, 25'd1, 1'b1},
         '{ROW_CSR,   CSR_DARK_FRACTION, 17'd65536,  8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_DARK_LEVEL,    17'd255,    8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd255, 1'b1, 6'd63, 25'd1, 1'b1},
         '{ROW_CSR,   CSR_DARK_FRACTION, 17'h1FFFF,  8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_DARK_LEVEL,    17'd0,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd0,   1'b1, 6'd0,  25'd1, 1'b1},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd1,   1'b1, 6'd0,  25'd1, 1'b0},
         '{ROW_CSR,   CSR_NO_REG_A,      17'h1FFFF,  8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_NO_REG_B,      17'd0,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_FRAME_WIDTH,   17'd0,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_FRAME_HEIGHT,  17'd0,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd128, 1'b1, 6'd32, 25'd1, 1'b0},
         '{ROW_CSR,   CSR_COL_STEP,      17'd0,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_ROW_STEP,      17'd0,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_FRAME_WIDTH,   17'h1E003,  8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_FRAME_HEIGHT,  17'd2,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_DARK_LEVEL,    17'd100,    8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_DARK_FRACTION, 17'd32768,  8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd10,  1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd99,  1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd100, 1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd101, 1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd250, 1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd7,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_COL_STEP,      17'd31,     8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_CSR,   CSR_ROW_STEP,      17'd31,     8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd255, 1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd0,   1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd64,  1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd128, 1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd192, 1'b0, 6'd0,  25'd0, 1'b0},
         '{ROW_PIXEL, CSR_FRAME_WIDTH,   17'd0,      8'd3,   1'b0, 6'd0,  25'd0, 1'b0}
      };
      hist_reset();
      reset     <= 1'b1;
      start     <= 1'b0;
      req_luma  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      prev_pix = 1'b0;
      for (int r = 0; r < DIR_ROWS; r++) begin
         row = dir_tab[r];
         if (row.kind == ROW_CSR) begin
            if (prev_pix) wait_idle();
            cfg_write(row.idx, row.wdata);
            prev_pix = 1'b0;
         end else begin
            if (!prev_pix) csr_we <= 1'b0;
            send_pixel(row.luma, fe);
            if (row.typed && fe) begin
               repeat (NUM_BINS) void'(pending_bins.pop_back());
               for (int i = 0; i < NUM_BINS; i++) begin
                  beat.index = 6'(i);
                  beat.count = (6'(i) == row.bin) ? row.cnt : '0;
                  beat.dark  = row.dark;
                  beat.last  = (i == NUM_BINS - 1);
                  pending_bins.push_back(beat);
               end
            end
            prev_pix = 1'b1;
         end
      end
      wait_idle();

      // oversized dimensions, a short stretch before small frames cut in mid-frame
      cfg_write(CSR_FRAME_WIDTH, 17'd8191);
      cfg_write(CSR_FRAME_HEIGHT, 17'd8191);
      cfg_write(CSR_COL_STEP, 17'd16);
      cfg_write(CSR_ROW_STEP, 17'd1);
      csr_we <= 1'b0;
      run_phase(BIG_PIXELS, 1'b0, 1'b0, 1'b0);
      wait_idle();

      // small frames, phases often stop mid-frame before the next settings
      base = pixels_sent;
      while (pixels_sent - base < RAND_PIXELS) begin
         rand_settings();
         span = int'(dim_eff(cfg_width)) * int'(dim_eff(cfg_height));
         run_phase($urandom_range(1, 3 * span), 1'b0, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 2) == 0);
         wait_idle();
      end

      repeat (NUM_BINS + SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_bins.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
